// ===== design/escd_pkg.sv =====
// ----------------------------------------------------------------------------
// escd_pkg
// Shared types, character constants and the hex digit helper for the
// escape sequence decoder.
// ----------------------------------------------------------------------------
package escd_pkg;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam int unsigned MAX_RESULTS = 3;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_HEX1  = 2'd2,
        MODE_HEX2  = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]       count;
        logic [2:0][7:0]  bytes;
        logic             bad;
    } t_results;

    typedef struct packed {
        t_mode      mode;
        logic       load_hi;
        logic [3:0] hi;
        logic       hi_bad;
    } t_next_state;

    // returns {bad, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            return {1'b0, d[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            return {1'b0, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            return {1'b0, d[3:0]};
        end
        return 5'b1_0000;
    endfunction

endpackage

// ===== design/escape_sequence_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_decoder_unit
// Decodes a C-style escaped byte stream (\" \n \r \t \xHH) into raw bytes.
// ----------------------------------------------------------------------------
// One input byte is decoded per cycle, unless o_stall holds it, into a result
// buffer of up to three bytes, which drains one byte per cycle while i_stall
// is low. Items with at most one result sustain one byte per cycle unless the
// sink stalls; an item that produces two or three bytes (an unknown escape or
// an escape cut short by the end of the string) holds the input side while the
// buffer drains. out_last marks the final byte of each input transaction.
module escape_sequence_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_bad_hex
);
    import escd_pkg::*;

    t_mode            r_mode;
    logic [3:0]       r_hi;
    logic             r_hi_bad;
    logic [1:0]       r_cnt;
    logic [2:0][7:0]  r_bytes;
    logic [2:0]       r_bad;

    t_next_state      dec_next;
    t_results         dec_res;
    logic             in_accept;
    logic             out_pop;

    escd_decode u_decode (
        .i_mode    (r_mode),
        .i_hi      (r_hi),
        .i_hi_bad  (r_hi_bad),
        .i_in_byte (i_in_byte),
        .i_in_end  (i_in_end),
        .o_next    (dec_next),
        .o_res     (dec_res)
    );

    assign o_valid    = (r_cnt != 2'd0);
    assign out_pop    = o_valid && !i_stall;
    assign o_stall    = (r_cnt > 2'd1) || (r_cnt == 2'd1 && i_stall);
    assign in_accept  = i_valid && !o_stall;
    assign o_out_byte = r_bytes[0];
    assign o_out_last = (r_cnt == 2'd1);
    assign o_bad_hex  = r_bad[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PLAIN;
            r_hi     <= 4'd0;
            r_hi_bad <= 1'b0;
        end else if (in_accept) begin
            r_mode <= dec_next.mode;
            if (dec_next.load_hi) begin
                r_hi     <= dec_next.hi;
                r_hi_bad <= dec_next.hi_bad;
            end
        end
    end

    // result buffer, entry 0 is presented on the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (in_accept) begin
            r_cnt <= dec_res.count;
        end else if (out_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_bytes <= dec_res.bytes;
            r_bad   <= {2'b00, dec_res.bad};
        end else if (out_pop) begin
            r_bytes <= {8'd0, r_bytes[2], r_bytes[1]};
            r_bad   <= {1'b0, r_bad[2], r_bad[1]};
        end
    end

endmodule

// ===== design/escd_decode.sv =====
// ----------------------------------------------------------------------------
// escd_decode
// Combinational decode of one input byte against the current escape mode:
// next mode and the zero to three result bytes it produces.
// ----------------------------------------------------------------------------
module escd_decode (
    input  escd_pkg::t_mode       i_mode,
    input  logic [3:0]            i_hi,
    input  logic                  i_hi_bad,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_in_end,
    output escd_pkg::t_next_state o_next,
    output escd_pkg::t_results    o_res
);
    import escd_pkg::*;

    logic [4:0] hex;

    assign hex = hex_value(i_in_byte);

    // next state
    always_comb begin
        o_next.mode    = MODE_PLAIN;
        o_next.load_hi = 1'b0;
        o_next.hi      = hex[3:0];
        o_next.hi_bad  = hex[4];
        unique case (i_mode)
            MODE_PLAIN: begin
                if (i_in_byte == CH_BSLASH && !i_in_end) begin
                    o_next.mode = MODE_ESC;
                end
            end
            MODE_ESC: begin
                if (i_in_byte == CH_X && !i_in_end) begin
                    o_next.mode = MODE_HEX1;
                end else if (i_in_byte == CH_BSLASH && !i_in_end) begin
                    o_next.mode = MODE_ESC;
                end
            end
            MODE_HEX1: begin
                o_next.load_hi = 1'b1;
                if (!i_in_end) begin
                    o_next.mode = MODE_HEX2;
                end
            end
            MODE_HEX2: begin
                o_next.mode = MODE_PLAIN;
            end
            default: begin
                o_next.mode = MODE_PLAIN;
            end
        endcase
    end

    // results
    always_comb begin
        o_res.count = 2'd0;
        o_res.bytes = '0;
        o_res.bad   = 1'b0;
        unique case (i_mode)
            MODE_PLAIN: begin
                if (!(i_in_byte == CH_BSLASH && !i_in_end)) begin
                    o_res.count    = 2'd1;
                    o_res.bytes[0] = i_in_byte;
                end
            end
            MODE_ESC: begin
                priority if (i_in_byte == CH_QUOTE) begin
                    o_res.count    = 2'd1;
                    o_res.bytes[0] = CH_QUOTE;
                end else if (i_in_byte == CH_N) begin
                    o_res.count    = 2'd1;
                    o_res.bytes[0] = CH_LF;
                end else if (i_in_byte == CH_R) begin
                    o_res.count    = 2'd1;
                    o_res.bytes[0] = CH_CR;
                end else if (i_in_byte == CH_T) begin
                    o_res.count    = 2'd1;
                    o_res.bytes[0] = CH_TAB;
                end else if (i_in_byte == CH_X) begin
                    if (i_in_end) begin
                        o_res.count    = 2'd2;
                        o_res.bytes[0] = CH_BSLASH;
                        o_res.bytes[1] = CH_X;
                    end
                end else if (i_in_byte == CH_BSLASH && !i_in_end) begin
                    o_res.count    = 2'd1;
                    o_res.bytes[0] = CH_BSLASH;
                end else begin
                    o_res.count    = 2'd2;
                    o_res.bytes[0] = CH_BSLASH;
                    o_res.bytes[1] = i_in_byte;
                end
            end
            MODE_HEX1: begin
                if (i_in_end) begin
                    o_res.count    = 2'd3;
                    o_res.bytes[0] = CH_BSLASH;
                    o_res.bytes[1] = CH_X;
                    o_res.bytes[2] = i_in_byte;
                end
            end
            MODE_HEX2: begin
                o_res.count    = 2'd1;
                o_res.bytes[0] = {i_hi, hex[3:0]};
                o_res.bad      = hex[4] | i_hi_bad;
            end
            default: begin
                o_res.count = 2'd0;
            end
        endcase
    end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// escape sequence decoder testbench
// Sends directed and random escaped strings into the decoder, predicts the
// decoded bytes with a behavioral model of the escape rules and checks every
// result transaction in order, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import escd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam string HEX_CHARS = "0123456789abcdefABCDEF";

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       bad_hex;
    } t_decoded;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_in_byte = 8'd0;
    logic       i_in_end = 1'b0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_out_last;
    logic       o_bad_hex;

    t_decoded   decoded_fifo[$];
    t_decoded   item_bytes[$];
    t_mode      dec_mode = MODE_PLAIN;
    logic [3:0] hi_nibble = 4'd0;
    logic       hi_nibble_bad = 1'b0;

    int unsigned send_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned items_sent = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    escape_sequence_decoder_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_byte  (i_in_byte),
        .i_in_end   (i_in_end),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last),
        .o_bad_hex  (o_bad_hex)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [3:0] digit_value(input logic [7:0] c, output logic bad);
        bad = 1'b0;
        if (c >= "0" && c <= "9") return 4'(c - "0");
        if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
        if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
        bad = 1'b1;
        return 4'd0;
    endfunction

    function automatic void emit_byte(input logic [7:0] b, input logic bad);
        item_bytes.push_back('{out_byte: b, out_last: 1'b0, bad_hex: bad});
    endfunction

    function automatic void plain_char(input logic [7:0] c, input logic fin);
        if (c == CH_BSLASH && !fin) begin
            dec_mode = MODE_ESC;
        end else begin
            emit_byte(c, 1'b0);
            dec_mode = MODE_PLAIN;
        end
    endfunction

    function automatic void decode_char(input logic [7:0] c, input logic fin);
        logic       lo_bad;
        logic [3:0] lo;
        item_bytes.delete();
        case (dec_mode)
            MODE_PLAIN: begin
                plain_char(c, fin);
            end
            MODE_ESC: begin
                dec_mode = MODE_PLAIN;
                if (c == CH_QUOTE) begin
                    emit_byte(CH_QUOTE, 1'b0);
                end else if (c == CH_N) begin
                    emit_byte(CH_LF, 1'b0);
                end else if (c == CH_R) begin
                    emit_byte(CH_CR, 1'b0);
                end else if (c == CH_T) begin
                    emit_byte(CH_TAB, 1'b0);
                end else if (c == CH_X) begin
                    if (fin) begin
                        emit_byte(CH_BSLASH, 1'b0);
                        emit_byte(CH_X, 1'b0);
                    end else begin
                        dec_mode = MODE_HEX1;
                    end
                end else begin
                    emit_byte(CH_BSLASH, 1'b0);
                    plain_char(c, fin);
                end
            end
            MODE_HEX1: begin
                hi_nibble = digit_value(c, hi_nibble_bad);
                if (fin) begin
                    emit_byte(CH_BSLASH, 1'b0);
                    emit_byte(CH_X, 1'b0);
                    emit_byte(c, 1'b0);
                    dec_mode = MODE_PLAIN;
                end else begin
                    dec_mode = MODE_HEX2;
                end
            end
            default: begin
                lo = digit_value(c, lo_bad);
                emit_byte({hi_nibble, lo}, lo_bad | hi_nibble_bad);
                dec_mode = MODE_PLAIN;
            end
        endcase
        if (item_bytes.size() > 0) item_bytes[item_bytes.size() - 1].out_last = 1'b1;
        foreach (item_bytes[k]) decoded_fifo.push_back(item_bytes[k]);
    endfunction

    // one input transaction, with idle cycles before it
    task automatic send_char(input logic [7:0] c, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= c;
        i_in_end  <= fin;
        do @(posedge i_clk); while (o_stall);
        decode_char(c, fin);
        items_sent++;
    endtask

    task automatic send_string(input string s, input logic fin);
        for (int i = 0; i < s.len(); i++) send_char(s[i], fin && (i == s.len() - 1));
    endtask

    task automatic test_plain_extremes();
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_simple_escapes();
        send_string("\\\"\\n\\r\\t", 1'b1);
    endtask

    task automatic test_hex_escapes();
        send_string("\\xG9\\xaZ", 1'b1);
    endtask

    task automatic test_unknown_escapes();
        send_string("\\q\\\\", 1'b1);
    endtask

    task automatic test_cut_short();
        send_string("\\", 1'b1);
        send_string("\\x", 1'b1);
        send_string("\\xA", 1'b1);
    endtask

    task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct,
                               input int unsigned n_items);
        logic [7:0]  str[$];
        int unsigned stop_at;
        int unsigned n_keep;
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            str.delete();
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8)) str.push_back(8'($urandom_range(0, 255)));
                foreach (str[k]) send_char(str[k], $urandom_range(0, 3) == 0);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 8))
                        0, 1, 2, 3: str.push_back(8'($urandom_range(0, 255)));
                        4: begin
                            str.push_back(CH_BSLASH);
                            case ($urandom_range(0, 3))
                                0: str.push_back(CH_QUOTE);
                                1: str.push_back(CH_N);
                                2: str.push_back(CH_R);
                                default: str.push_back(CH_T);
                            endcase
                        end
                        5, 6: begin
                            str.push_back(CH_BSLASH);
                            str.push_back(CH_X);
                            repeat (2) begin
                                if ($urandom_range(0, 9) == 0)
                                    str.push_back(8'($urandom_range(0, 255)));
                                else
                                    str.push_back(HEX_CHARS[$urandom_range(0, 21)]);
                            end
                        end
                        default: begin
                            str.push_back(CH_BSLASH);
                            str.push_back(8'($urandom_range(0, 255)));
                        end
                    endcase
                end
                n_keep = str.size();
                if ($urandom_range(0, 4) == 0) n_keep = $urandom_range(1, str.size());
                for (int i = 0; i < n_keep; i++) send_char(str[i], i == n_keep - 1);
            end
        end
        i_valid <= 1'b0;
        while (decoded_fifo.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_decoded want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (decoded_fifo.size() == 0) begin
                $error("unexpected result transaction: out_byte %0h", o_out_byte);
                error_count++;
            end else begin
                want = decoded_fifo.pop_front();
                if (o_out_byte !== want.out_byte) begin
                    $error("out_byte mismatch: expected %0h, actual %0h",
                           want.out_byte, o_out_byte);
                    error_count++;
                end
                if (o_out_last !== want.out_last) begin
                    $error("out_last mismatch: expected %0b, actual %0b",
                           want.out_last, o_out_last);
                    error_count++;
                end
                if (o_bad_hex !== want.bad_hex) begin
                    $error("bad_hex mismatch: expected %0b, actual %0b",
                           want.bad_hex, o_bad_hex);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_plain_extremes();
        test_simple_escapes();
        test_hex_escapes();
        test_unknown_escapes();
        test_cut_short();
        test_random(18, 53, 170);
        test_random(53, 18, 170);
        test_random(0, 0, 170);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && decoded_fifo.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== escape_sequence_decoder_unit.f =====
design/escd_pkg.sv
design/escd_decode.sv
design/escape_sequence_decoder_unit.sv
bench/testbench.sv
